### hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Request codes, result status codes, stream field positions and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Stream payload layout (lowest field first, padded to whole bytes)
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_MODE_LSB = 0;
    localparam int IN_DATA_LSB = IN_MODE_LSB + MODE_W;
    localparam int IN_POS_LSB  = IN_DATA_LSB + WORD_W;
    localparam int OUT_DATA_LSB  = 0;
    localparam int OUT_STAT_LSB  = OUT_DATA_LSB + WORD_W;
    localparam int OUT_COUNT_LSB = OUT_STAT_LSB + STAT_W;
    localparam int OUT_EMPTY_LSB = OUT_COUNT_LSB + COUNT_W;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ_INDEX = 3'd6;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd7;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Ring address selects
    localparam int ADR_SEL_W = 3;
    localparam logic [ADR_SEL_W-1:0] ADR_HEAD     = 3'd0; // current front
    localparam logic [ADR_SEL_W-1:0] ADR_NEW_HEAD = 3'd1; // slot before front
    localparam logic [ADR_SEL_W-1:0] ADR_TAIL     = 3'd2; // slot after back
    localparam logic [ADR_SEL_W-1:0] ADR_LAST     = 3'd3; // current back
    localparam logic [ADR_SEL_W-1:0] ADR_POS      = 3'd4; // indexed from front

    // Controller to datapath
    typedef struct packed {
        logic                  take;     // latch status of a new transaction
        logic [STAT_W-1:0]     status;
        logic                  mem_wr;
        logic                  mem_rd;
        logic [ADR_SEL_W-1:0]  adr_sel;
        logic                  head_inc;
        logic                  head_dec;
        logic                  cnt_inc;
        logic                  cnt_dec;
        logic                  clear;
        logic                  load;     // move result into output register
    } t_dq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_ok;   // requested index below the count
    } t_dq_sts;

endpackage

### hw/rtl/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer for the double-ended queue
// Decodes each accepted request against the queue status, issues the
// datapath commands and owns the result valid flag.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  t_dq_sts           i_sts,
    output t_dq_cmd           o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESULT = 1'b1;

    logic    r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dq_cmd w_cmd;

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Decode and sequencing
    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    w_cmd.status = ST_OK;
                    n_state = S_RESULT;
                    unique case (i_mode)
                        MODE_PUSH_FRONT: begin
                            if (i_sts.full) begin
                                w_cmd.status = ST_FULL;
                            end else begin
                                w_cmd.mem_wr   = 1'b1;
                                w_cmd.adr_sel  = ADR_NEW_HEAD;
                                w_cmd.head_dec = 1'b1;
                                w_cmd.cnt_inc  = 1'b1;
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (i_sts.full) begin
                                w_cmd.status = ST_FULL;
                            end else begin
                                w_cmd.mem_wr  = 1'b1;
                                w_cmd.adr_sel = ADR_TAIL;
                                w_cmd.cnt_inc = 1'b1;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (i_sts.empty) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.mem_rd   = 1'b1;
                                w_cmd.adr_sel  = ADR_HEAD;
                                w_cmd.head_inc = 1'b1;
                                w_cmd.cnt_dec  = 1'b1;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (i_sts.empty) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.mem_rd  = 1'b1;
                                w_cmd.adr_sel = ADR_LAST;
                                w_cmd.cnt_dec = 1'b1;
                            end
                        end
                        MODE_READ_FRONT: begin
                            if (i_sts.empty) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.mem_rd  = 1'b1;
                                w_cmd.adr_sel = ADR_HEAD;
                            end
                        end
                        MODE_READ_BACK: begin
                            if (i_sts.empty) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.mem_rd  = 1'b1;
                                w_cmd.adr_sel = ADR_LAST;
                            end
                        end
                        MODE_READ_INDEX: begin
                            if (!i_sts.pos_ok) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.mem_rd  = 1'b1;
                                w_cmd.adr_sel = ADR_POS;
                            end
                        end
                        MODE_CLEAR: begin
                            w_cmd.clear = 1'b1;
                        end
                    endcase
                end
            end
            S_RESULT: begin
                // memory read data is ready; wait for a free output register
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid: load wins over a same-cycle drain
    always_comb begin
        if (w_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/dq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_dp: datapath of the double-ended queue
// Ring store with registered read port, head pointer and entry count,
// pending status and the result output register.
// ----------------------------------------------------------------------------
module dq_dp
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dq_cmd            i_cmd,
    output t_dq_sts            o_sts,
    input  logic [WORD_W-1:0]  i_push_data,
    input  logic [POS_W-1:0]   i_position,
    output logic [WORD_W-1:0]  o_read_data,
    output logic [STAT_W-1:0]  o_status,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic               o_is_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] RING_LEN  = SUM_W'(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [PTR_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [STAT_W-1:0]     r_status;
    logic                  r_rd_ok;
    logic [WORD_W-1:0]     r_out_data;
    logic [STAT_W-1:0]     r_out_status;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_empty;

    logic [SUM_W-1:0]      w_offset;
    logic [SUM_W-1:0]      w_sum;
    logic [PTR_W-1:0]      w_slot;
    logic [PTR_W-1:0]      w_head_m1;
    logic [PTR_W-1:0]      w_addr;

    // Status toward the controller
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.full   = (r_count == FULL_CNT);
    assign o_sts.pos_ok = (32'(i_position) < 32'(r_count));

    // Ring slot at an offset from the head (sum stays below twice the depth)
    always_comb begin
        priority case (i_cmd.adr_sel)
            ADR_TAIL: w_offset = SUM_W'(r_count);
            ADR_LAST: w_offset = SUM_W'(r_count) - SUM_W'(1);
            ADR_POS:  w_offset = SUM_W'(i_position);
            default:  w_offset = '0;
        endcase
        w_sum     = SUM_W'(r_head) + w_offset;
        w_slot    = (w_sum >= RING_LEN) ? PTR_W'(w_sum - RING_LEN) : PTR_W'(w_sum);
        w_head_m1 = (r_head == '0) ? LAST_SLOT : r_head - PTR_W'(1);
        w_addr    = (i_cmd.adr_sel == ADR_NEW_HEAD) ? w_head_m1 : w_slot;
    end

    // Ring store, one access per transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= DATA_WIDTH'(i_push_data);
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // Head and count update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.clear) begin
            n_head  = '0;
            n_count = '0;
        end else begin
            if (i_cmd.head_dec) begin
                n_head = w_head_m1;
            end else if (i_cmd.head_inc) begin
                n_head = (r_head == LAST_SLOT) ? '0 : r_head + PTR_W'(1);
            end
            if (i_cmd.cnt_inc) begin
                n_count = r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Pending result status of the transaction in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status <= i_cmd.status;
            r_rd_ok  <= i_cmd.mem_rd;
        end
    end

    // Output register; count already reflects the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data   <= r_rd_ok ? WORD_W'(r_rdata) : '0;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_read_data   = r_out_data;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;

endmodule

### hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a ring store
// Push/pop at either end, read front, back or an indexed entry, clear.
// ----------------------------------------------------------------------------
// Each request is handled in an accept cycle and a result state: the accept
// cycle decodes it, updates head and count and issues the one access to the
// ring store, and the result state moves the registered read word into the
// output register once that register is free.
// A finished result waits in the output register while the next request is
// accepted; a stalled result side holds a further request in its result
// state. Every request gives exactly one result. The store needs no clearing
// after reset: only entries written by a push are ever returned.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mode[2:0], push_data[34:3], position[38:35], zero pad[39]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_data[31:0], status[33:32], entry_count[38:34], is_empty[39]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    t_dq_cmd            w_cmd;
    t_dq_sts            w_sts;
    logic [WORD_W-1:0]  w_read_data;
    logic [STAT_W-1:0]  w_status;
    logic [COUNT_W-1:0] w_entry_count;
    logic               w_is_empty;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_mode      (s_tdata[IN_MODE_LSB +: MODE_W]),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_push_data   (s_tdata[IN_DATA_LSB +: WORD_W]),
        .i_position    (s_tdata[IN_POS_LSB +: POS_W]),
        .o_read_data   (w_read_data),
        .o_status      (w_status),
        .o_entry_count (w_entry_count),
        .o_is_empty    (w_is_empty)
    );

    assign m_tdata = {w_is_empty, w_entry_count, w_status, w_read_data};

endmodule

### hw/rtl/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One transaction in flight: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[OUT_STAT_LSB +: STAT_W] == ST_OK ||
                      m_tdata[OUT_STAT_LSB +: STAT_W] == ST_EMPTY ||
                      m_tdata[OUT_STAT_LSB +: STAT_W] == ST_FULL))
        else $error("undefined status code");

    // Empty flag agrees with the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[OUT_EMPTY_LSB] ==
                      (m_tdata[OUT_COUNT_LSB +: COUNT_W] == '0)))
        else $error("empty flag disagrees with count");

    // Failed requests return a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[OUT_STAT_LSB +: STAT_W] != ST_OK)
            |-> (m_tdata[OUT_DATA_LSB +: WORD_W] == '0))
        else $error("nonzero data on failed request");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_scoreboard: scoreboard for the double-ended queue
// Watches both stream channels, keeps its own ring copy of the queue, works
// out the result of every accepted request and compares each returned result
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dq_scoreboard
    import dq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // mode, push_data, position, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // read_data, status, entry_count, is_empty
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_full_hits,
    output int                     o_empty_hits
);

    localparam int RING = DEPTH_DEF;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_deque_result;

    // Shadow copy of the queue
    logic [WORD_W-1:0] ring_words [RING];
    int                front_idx;
    int                held_count;

    t_deque_result     awaited_results [$];
    int                fails;
    int                checked;
    int                full_hits;
    int                empty_hits;

    // Apply one request to the shadow queue and return its result
    function automatic t_deque_result deque_apply(input logic [MODE_W-1:0] mode,
                                                  input logic [WORD_W-1:0] word,
                                                  input logic [POS_W-1:0]  pos);
        t_deque_result r;
        r = '0;
        r.status = ST_OK;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (held_count >= RING) begin
                    r.status = ST_FULL;
                end else begin
                    front_idx = (front_idx + RING - 1) % RING;
                    ring_words[front_idx] = word;
                    held_count++;
                end
            end
            MODE_PUSH_BACK: begin
                if (held_count >= RING) begin
                    r.status = ST_FULL;
                end else begin
                    ring_words[(front_idx + held_count) % RING] = word;
                    held_count++;
                end
            end
            MODE_POP_FRONT: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = ring_words[front_idx];
                    front_idx = (front_idx + 1) % RING;
                    held_count--;
                end
            end
            MODE_POP_BACK: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = ring_words[(front_idx + held_count - 1) % RING];
                    held_count--;
                end
            end
            MODE_READ_FRONT: begin
                if (held_count == 0) r.status = ST_EMPTY;
                else r.word = ring_words[front_idx];
            end
            MODE_READ_BACK: begin
                if (held_count == 0) r.status = ST_EMPTY;
                else r.word = ring_words[(front_idx + held_count - 1) % RING];
            end
            MODE_READ_INDEX: begin
                if (int'(pos) >= held_count) r.status = ST_EMPTY;
                else r.word = ring_words[(front_idx + int'(pos)) % RING];
            end
            default: begin
                // clear
                held_count = 0;
                front_idx  = 0;
            end
        endcase
        if (r.status != ST_OK) r.word = '0;
        r.count = held_count[COUNT_W-1:0];
        r.empty = (held_count == 0);
        return r;
    endfunction

    // Compare returned results, then predict newly accepted requests
    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        logic          bad;
        if (!i_rst_n) begin
            front_idx  = 0;
            held_count = 0;
            fails      = 0;
            checked    = 0;
            full_hits  = 0;
            empty_hits = 0;
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.word   = i_m_tdata[OUT_DATA_LSB  +: WORD_W];
                got.status = i_m_tdata[OUT_STAT_LSB  +: STAT_W];
                got.count  = i_m_tdata[OUT_COUNT_LSB +: COUNT_W];
                got.empty  = i_m_tdata[OUT_EMPTY_LSB];
                if (awaited_results.size() == 0) begin
                    $error("result transaction with no request outstanding: %h", i_m_tdata);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    bad  = 1'b0;
                    if (got.word !== want.word) begin
                        $error("read_data: expected %h, got %h", want.word, got.word);
                        bad = 1'b1;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        bad = 1'b1;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        bad = 1'b1;
                    end
                    if (got.empty !== want.empty) begin
                        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                        bad = 1'b1;
                    end
                    if (bad) fails++;
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = deque_apply(i_s_tdata[IN_MODE_LSB +: MODE_W],
                                   i_s_tdata[IN_DATA_LSB +: WORD_W],
                                   i_s_tdata[IN_POS_LSB  +: POS_W]);
                if (want.status == ST_FULL)  full_hits++;
                if (want.status == ST_EMPTY) empty_hits++;
                awaited_results.push_back(want);
            end
        end
        // registered so the stimulus side samples them without races
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_full_hits  <= full_hits;
        o_empty_hits <= empty_hits;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level test of the double-ended queue
// A directed opening hits empty and full corners, out-of-range reads and
// clear; random phases then swing the queue between full and empty under
// bursty requests and a stalling result side. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import dq_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 5000;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;

    int cycle_count   = 0;
    int sent_count    = 0;
    int directed_sent = 0;
    int burst_left    = 0;
    int drain_pauses  = 0;

    always #5 i_clk = ~i_clk;

    double_ended_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dq_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_hits  (full_hits),
        .o_empty_hits (empty_hits)
    );

    // Run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side: stretches of free flow, light and heavy back-pressure
    int stall_style = 0;
    int style_left  = 0;
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(2);
            style_left  = $urandom_range(120, 10);
        end
        style_left--;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(1));
            default: m_tready <= ($urandom_range(4) == 0);
        endcase
    end

    // One request transaction, then a random gap when the burst runs out
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word,
                         input logic [POS_W-1:0] pos);
        logic [IN_TDATA_W-1:0] packed_req;
        packed_req = '0;
        packed_req[IN_MODE_LSB +: MODE_W] = mode;
        packed_req[IN_DATA_LSB +: WORD_W] = word;
        packed_req[IN_POS_LSB  +: POS_W]  = pos;
        s_tdata  <= packed_req;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(12);
        end
    endtask

    // Hold requests back until every outstanding result has returned
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        drain_pauses++;
    endtask

    initial begin
        logic [MODE_W-1:0] mode;
        int                push_pct;
        int                phase_left;
        int                pick;
        int                waited;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty errors, both ends, out-of-range index, full, clear
        issue(MODE_POP_FRONT,  '0, '0);
        issue(MODE_POP_BACK,   '0, '0);
        issue(MODE_READ_FRONT, '0, '0);
        issue(MODE_READ_INDEX, '0, '0);
        issue(MODE_PUSH_FRONT, 32'h0000_0000, '0);
        issue(MODE_PUSH_BACK,  32'hFFFF_FFFF, '1);
        issue(MODE_READ_BACK,  '0, '0);
        issue(MODE_READ_INDEX, '0, 4'd2);
        for (int i = 0; i < DEPTH_DEF - 2; i++) begin
            issue(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                  i[0] ? (32'h5A5A_0000 | i) : ~(32'h5A5A_0000 | i), 4'(i));
        end
        issue(MODE_PUSH_BACK,  32'hDEAD_BEEF, '0);
        issue(MODE_PUSH_FRONT, 32'hBEEF_DEAD, '0);
        issue(MODE_READ_INDEX, '0, 4'd15);
        issue(MODE_POP_FRONT,  '0, '0);
        issue(MODE_POP_BACK,   '0, '0);
        issue(MODE_CLEAR,      '0, '0);
        directed_sent = sent_count;
        wait_drained();

        // Random phases that lean toward filling, draining or mixing
        phase_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(80, 20);
                case ($urandom_range(2))
                    0:       push_pct = 75;
                    1:       push_pct = 20;
                    default: push_pct = 45;
                endcase
            end
            phase_left--;
            pick = $urandom_range(99);
            if (pick < 2) begin
                mode = MODE_CLEAR;
            end else if (pick < 2 + push_pct) begin
                mode = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                case ($urandom_range(4))
                    0:       mode = MODE_POP_FRONT;
                    1:       mode = MODE_POP_BACK;
                    2:       mode = MODE_READ_FRONT;
                    3:       mode = MODE_READ_BACK;
                    default: mode = MODE_READ_INDEX;
                endcase
            end
            issue(mode, $urandom(), POS_W'($urandom_range(15)));
            if (phase_left == 0 && $urandom_range(3) == 0) wait_drained();
        end

        // Let every result come home, then a short settle
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests (%0d directed), %0d results checked, %0d drain pauses",
                 sent_count, directed_sent, checked, drain_pauses);
        $display("refused pushes on a full queue: %0d, empty or out-of-range errors: %0d",
                 full_hits, empty_hits);
        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_dp.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
tb/dq_checker.sv
tb/testbench.sv
